### hw/rtl/cfp_pkg.sv
// command frame parser package: character codes, frame ids, state encodings
// and the number conversion state shared by cfp_num_feed and the top level
// no dependencies
package cfp_pkg;

  localparam int unsigned NumW = 32;
  localparam int unsigned IdW = 24;
  localparam int unsigned PayloadMaxDefault = 16;

  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChEnd   = 8'h21;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [NumW-1:0] DistReset = NumW'(20);

  localparam logic [IdW-1:0] IdTkf = {8'h54, 8'h4B, 8'h46};
  localparam logic [IdW-1:0] IdStp = {8'h53, 8'h54, 8'h50};
  localparam logic [IdW-1:0] IdLat = {8'h4C, 8'h41, 8'h54};
  localparam logic [IdW-1:0] IdLon = {8'h4C, 8'h4F, 8'h4E};
  localparam logic [IdW-1:0] IdSrd = {8'h53, 8'h52, 8'h44};

  typedef enum logic [2:0] {
    PhWait    = 3'b001,
    PhId      = 3'b010,
    PhPayload = 3'b100
  } parse_phase_e;

  typedef enum logic [2:0] {
    NumSkip   = 3'b001,
    NumDigits = 3'b010,
    NumDone   = 3'b100
  } num_phase_e;

  typedef struct packed {
    num_phase_e      phase;
    logic            negative;
    logic [NumW-1:0] acc;
  } num_state_t;

  localparam num_state_t NumStateReset = '{phase: NumSkip, negative: 1'b0, acc: '0};

endpackage

### hw/rtl/cfp_num_feed.sv
// one payload character step of the decimal converter: whitespace skip,
// optional sign, digit accumulate with wrap
// depends on cfp_pkg
module cfp_num_feed
  import cfp_pkg::*;
(
  input  logic [7:0] char_i,
  input  num_state_t state_i,
  output num_state_t state_o
);

  logic            is_space;
  logic            is_digit;
  logic            is_sign;
  logic [NumW-1:0] acc_next;

  assign is_space = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_sign  = (char_i == ChPlus) || (char_i == ChMinus);
  // acc * 10 + digit
  assign acc_next = (state_i.acc << 3) + (state_i.acc << 1) + NumW'(char_i[3:0]);

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      NumSkip: begin
        if (is_sign) begin
          state_o.negative = (char_i == ChMinus);
          state_o.phase    = NumDigits;
        end else if (is_digit) begin
          state_o.acc   = acc_next;
          state_o.phase = NumDigits;
        end else if (!is_space) begin
          state_o.phase = NumDone;
        end
      end
      NumDigits: begin
        if (is_digit) begin
          state_o.acc = acc_next;
        end else begin
          state_o.phase = NumDone;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

### hw/rtl/command_frame_parser_core.sv
// command frame parser top level: frame state machine, stored values, flags
// depends on cfp_pkg and cfp_num_feed
//
// usage
//   input channel (in_valid_i / in_ready_o) takes one item per cycle unless
//   stalled: an optional received character (byte_valid_i, rx_byte_i) and
//   acknowledge bits that clear their flags before the character is handled
//   frames are '$', three id characters, a payload and '!'; TKF and STP set
//   the takeoff or land flag, LAT, LON and SRD store the decoded payload
//   output channel (out_valid_o / out_ready_i) returns one item per input
//   item: stored values, flags and frame_done
//   the result follows in the cycle after acceptance; throughput is one item
//   per cycle when not stalled, set by the single result register of state
//   the result register is the only buffer: in_ready_o is high while it is
//   empty or being drained, so a stalled receiver holds the input one item
//   behind
//   reset clears the parser to waiting for '$', all flags to zero, latitude
//   and longitude to zero and separation distance to 20, with no result
//   pending
module command_frame_parser_core
  import cfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PayloadMaxDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   byte_valid_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   ack_lat_i,
  input  logic                   ack_lon_i,
  input  logic                   ack_distance_i,
  input  logic                   ack_takeoff_i,
  input  logic                   ack_land_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [NumW-1:0] user_lat_o,
  output logic signed [NumW-1:0] user_lon_o,
  output logic signed [NumW-1:0] separation_distance_o,
  output logic                   takeoff_flag_o,
  output logic                   land_flag_o,
  output logic                   lat_fresh_o,
  output logic                   lon_fresh_o,
  output logic                   distance_fresh_o,
  output logic                   frame_done_o
);

  localparam int unsigned CntW = $clog2(PAYLOAD_MAX + 1);

  parse_phase_e    phase_q, phase_d;
  logic [1:0]      id_cnt_q, id_cnt_d;
  logic [IdW-1:0]  frame_id_q, frame_id_d;
  logic [CntW-1:0] pay_cnt_q, pay_cnt_d;
  num_state_t      num_q, num_d, num_fed;
  logic [NumW-1:0] lat_q, lat_d, lon_q, lon_d, dist_q, dist_d;
  logic            takeoff_q, takeoff_d, land_q, land_d;
  logic            lat_new_q, lat_new_d, lon_new_q, lon_new_d, dist_new_q, dist_new_d;
  logic            done_q, done_d;
  logic            out_valid_q;
  logic            accept;
  logic [NumW-1:0] num_value;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign num_value  = num_q.negative ? (NumW'(0) - num_q.acc) : num_q.acc;

  cfp_num_feed u_num_feed (
    .char_i  (rx_byte_i),
    .state_i (num_q),
    .state_o (num_fed)
  );

  always_comb begin
    phase_d    = phase_q;
    id_cnt_d   = id_cnt_q;
    frame_id_d = frame_id_q;
    pay_cnt_d  = pay_cnt_q;
    num_d      = num_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    dist_d     = dist_q;
    done_d     = 1'b0;
    takeoff_d  = takeoff_q  && !ack_takeoff_i;
    land_d     = land_q     && !ack_land_i;
    lat_new_d  = lat_new_q  && !ack_lat_i;
    lon_new_d  = lon_new_q  && !ack_lon_i;
    dist_new_d = dist_new_q && !ack_distance_i;
    if (byte_valid_i) begin
      case (phase_q)
        PhId: begin
          frame_id_d = {frame_id_q[IdW-9:0], rx_byte_i};
          id_cnt_d   = id_cnt_q + 2'd1;
          if (id_cnt_q == 2'd2) begin
            id_cnt_d  = '0;
            phase_d   = PhPayload;
            pay_cnt_d = '0;
            num_d     = NumStateReset;
          end
        end
        PhPayload: begin
          if (rx_byte_i == ChEnd) begin
            done_d    = 1'b1;
            phase_d   = PhWait;
            id_cnt_d  = '0;
            pay_cnt_d = '0;
            case (frame_id_q)
              IdTkf: begin
                takeoff_d = 1'b1;
                land_d    = 1'b0;
              end
              IdStp: begin
                land_d    = 1'b1;
                takeoff_d = 1'b0;
              end
              IdLat: begin
                lat_d     = num_value;
                lat_new_d = 1'b1;
              end
              IdLon: begin
                lon_d     = num_value;
                lon_new_d = 1'b1;
              end
              IdSrd: begin
                dist_d     = num_value;
                dist_new_d = 1'b1;
              end
              default: begin
                done_d = 1'b1;
              end
            endcase
          end else if (pay_cnt_q < CntW'(PAYLOAD_MAX)) begin
            num_d     = num_fed;
            pay_cnt_d = pay_cnt_q + CntW'(1);
          end
        end
        default: begin
          phase_d = PhWait;
          if (rx_byte_i == ChStart) begin
            phase_d  = PhId;
            id_cnt_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWait;
      id_cnt_q    <= '0;
      frame_id_q  <= '0;
      pay_cnt_q   <= '0;
      num_q       <= NumStateReset;
      lat_q       <= '0;
      lon_q       <= '0;
      dist_q      <= DistReset;
      takeoff_q   <= 1'b0;
      land_q      <= 1'b0;
      lat_new_q   <= 1'b0;
      lon_new_q   <= 1'b0;
      dist_new_q  <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        id_cnt_q   <= id_cnt_d;
        frame_id_q <= frame_id_d;
        pay_cnt_q  <= pay_cnt_d;
        num_q      <= num_d;
        lat_q      <= lat_d;
        lon_q      <= lon_d;
        dist_q     <= dist_d;
        takeoff_q  <= takeoff_d;
        land_q     <= land_d;
        lat_new_q  <= lat_new_d;
        lon_new_q  <= lon_new_d;
        dist_new_q <= dist_new_d;
        done_q     <= done_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign user_lat_o            = lat_q;
  assign user_lon_o            = lon_q;
  assign separation_distance_o = dist_q;
  assign takeoff_flag_o        = takeoff_q;
  assign land_flag_o           = land_q;
  assign lat_fresh_o           = lat_new_q;
  assign lon_fresh_o           = lon_new_q;
  assign distance_fresh_o      = dist_new_q;
  assign frame_done_o          = done_q;

`ifndef SYNTH
  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(takeoff_q && land_q))
    else $error("takeoff and land flags both set");

  a_done_to_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q == PhWait))
    else $error("frame done without return to start wait");

  a_pay_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_cnt_q <= CntW'(PAYLOAD_MAX))
    else $error("payload count beyond limit");

  a_state_holds_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(phase_q) && $stable(num_q))
    else $error("parser state moved while a result was pending");
`endif

endmodule
